FILE: hw/rtl/rgb_status_led_effect_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef RGB_STATUS_LED_EFFECT_ENGINE_ASSERT_SVH
`define RGB_STATUS_LED_EFFECT_ENGINE_ASSERT_SVH
// Assert that an implication holds at every clock edge outside reset.
`define RSL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert a property that also holds during reset.
`define RSL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hw/rtl/rsled_pkg.sv
// Package with shared types, constants, the sine table and color helpers.
package rsled_pkg;

  localparam int unsigned SineDepth = 256;
  localparam int unsigned SineIdxW = $clog2(SineDepth);

  localparam logic [2:0] ModeUnauth  = 3'd0;
  localparam logic [2:0] ModeRainbow = 3'd1;
  localparam logic [2:0] ModeEnroll  = 3'd2;
  localparam logic [2:0] ModeReset   = 3'd3;
  localparam logic [2:0] ModeStart   = 3'd4;
  localparam logic [2:0] ModeEnd     = 3'd5;
  localparam logic [2:0] ModeIdle    = 3'd6;
  localparam logic [2:0] ModeNone    = 3'd7;

  localparam logic [1:0] RegPeriod = 2'd0;
  localparam logic [1:0] RegHue    = 2'd1;
  localparam logic [1:0] RegBlink  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the update and decode mode
    logic div_start; // start the shared divider
    logic div_sel;   // 0: elapsed mod period, 1: elapsed / hue step
    logic idx_start; // start scaling of remainder into table index
    logic finish;    // commit result
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic [2:0] mode;
  } ctrl_sts_t;

  function automatic logic [7:0] sine_entry(input int unsigned i);
    logic [15:0] p;
    logic neg;
    logic [14:0] r;
    logic [63:0] x, x2, t, s;
    logic [63:0] one;
    one = 64'd1 << 30;
    p = 16'((64'(i) * 64'd65536) / 64'(SineDepth));
    neg = p[15];
    r = p[14:0];
    if (r > 15'd16384) r = 15'(16'd32768 - 16'(r));
    x = (64'(r) * 64'd1686629713) >> 14;
    x2 = (x * x) >> 30;
    t = one;
    t = one - ((x2 * t) >> 30) / 64'd110;
    t = one - ((x2 * t) >> 30) / 64'd72;
    t = one - ((x2 * t) >> 30) / 64'd42;
    t = one - ((x2 * t) >> 30) / 64'd20;
    t = one - ((x2 * t) >> 30) / 64'd6;
    s = (x * t) >> 30;
    if (s > one) s = one;
    if (neg) return 8'(((one - s) * 64'd255) >> 31);
    return 8'(((one + s) * 64'd255) >> 31);
  endfunction

  function automatic logic [23:0] base_color(input logic [2:0] mode);
    logic [23:0] c;
    unique case (mode)
      ModeUnauth: c = {8'd255, 8'd165, 8'd0};
      ModeEnroll: c = {8'd0, 8'd0, 8'd255};
      ModeReset:  c = {8'd128, 8'd0, 8'd128};
      ModeStart:  c = {8'd0, 8'd255, 8'd0};
      ModeEnd:    c = {8'd255, 8'd0, 8'd0};
      default:    c = 24'd0;
    endcase
    return c;
  endfunction

  // floor(v/255) for v < 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] e;
    e = 17'(v) + 17'd1 + 17'(v[15:8]);
    return e[15:8];
  endfunction

  function automatic logic [23:0] hue_to_rgb(input logic [7:0] h);
    logic [2:0] sector;
    logic [7:0] lo;
    logic [8:0] f;
    logic [7:0] q, t;
    logic [16:0] m;
    logic [23:0] c;
    // Sectors 0 to 4 span 43 hue steps each; sector 5 spans 41.
    priority if (h >= 8'd215) begin
      sector = 3'd5;
      lo = 8'd215;
    end else if (h >= 8'd172) begin
      sector = 3'd4;
      lo = 8'd172;
    end else if (h >= 8'd129) begin
      sector = 3'd3;
      lo = 8'd129;
    end else if (h >= 8'd86) begin
      sector = 3'd2;
      lo = 8'd86;
    end else if (h >= 8'd43) begin
      sector = 3'd1;
      lo = 8'd43;
    end else begin
      sector = 3'd0;
      lo = 8'd0;
    end
    f = 9'(h - lo) * 9'd6;
    m = 17'd255 * 17'(f);
    q = 8'((17'd255 * (17'd255 - (m >> 8))) >> 8);
    m = 17'd255 * 17'(9'd255 - f);
    t = 8'((17'd255 * (17'd255 - (m >> 8))) >> 8);
    unique case (sector)
      3'd0: c = {8'd255, t, 8'd0};
      3'd1: c = {q, 8'd255, 8'd0};
      3'd2: c = {8'd0, 8'd255, t};
      3'd3: c = {8'd0, q, 8'd255};
      3'd4: c = {t, 8'd0, 8'd255};
      default: c = {8'd255, 8'd0, q};
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/rsled_div.sv
// Shared radix-2 restoring divider, 32 by 32 bits, one quotient bit a cycle.
module rsled_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);
  logic [31:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  assign trial = {rem_q, quot_q[31]} - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o = rem_q;
endmodule

FILE: hw/rtl/rsled_datapath.sv
// Datapath: effect state, shared divider, sine lookup and drive registers.
module rsled_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsled_pkg::ctrl_cmd_t  cmd_i,
  output rsled_pkg::ctrl_sts_t  sts_o,
  input  logic [31:0]           now_ms_i,
  input  logic                  authenticated_i,
  input  logic                  resource_select_wait_i,
  input  logic [2:0]            tap_wait_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  output logic [7:0]            red_drive_o,
  output logic [7:0]            green_drive_o,
  output logic [7:0]            blue_drive_o,
  output logic [2:0]            mode_now_o
);
  logic [15:0] period_q, hstep_q, blink_q;
  logic [2:0]  cur_mode_q, mode_q, mode_d;
  logic        lit_q;
  logic [31:0] toggle_q, bstart_q, hstart_q, now_q;
  logic [7:0]  hue_q;
  logic [23:0] drive_q;
  logic [15:0] period_eff, hstep_eff;
  logic [31:0] div_a, div_b, quot, rem;
  logic        div_done;

  always_comb begin
    if (!authenticated_i) mode_d = rsled_pkg::ModeUnauth;
    else if (resource_select_wait_i) mode_d = rsled_pkg::ModeRainbow;
    else if (tap_wait_i >= 3'd1 && tap_wait_i <= 3'd4) mode_d = tap_wait_i + 3'd1;
    else mode_d = rsled_pkg::ModeIdle;
  end

  assign period_eff = (period_q == '0) ? 16'd1 : period_q;
  assign hstep_eff  = (hstep_q == '0) ? 16'd1 : hstep_q;

  logic [31:0] b_elapsed, h_elapsed;
  assign b_elapsed = now_q - bstart_q;
  assign h_elapsed = now_q - hstart_q;

  // Index stage uses the same divider: (rem*Depth)/period.
  always_comb begin
    if (cmd_i.idx_start) begin
      div_a = 32'(rem[15:0]) << rsled_pkg::SineIdxW;
      div_b = 32'(period_eff);
    end else if (cmd_i.div_sel) begin
      div_a = h_elapsed;
      div_b = 32'(hstep_eff);
    end else begin
      div_a = b_elapsed;
      div_b = 32'(period_eff);
    end
  end

  rsled_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start | cmd_i.idx_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  logic [7:0] sine_rom [rsled_pkg::SineDepth];
  always_comb begin
    for (int i = 0; i < int'(rsled_pkg::SineDepth); i++) begin
      sine_rom[i] = rsled_pkg::sine_entry(i);
    end
  end

  logic [7:0]  br;
  logic [23:0] base, breathe_drv, rainbow_rgb;
  assign br = sine_rom[quot[rsled_pkg::SineIdxW-1:0]];
  assign base = rsled_pkg::base_color(mode_q);
  assign breathe_drv = {8'd255 - rsled_pkg::div255(16'(br) * 16'(base[23:16])),
                        8'd255 - rsled_pkg::div255(16'(br) * 16'(base[15:8])),
                        8'd255 - rsled_pkg::div255(16'(br) * 16'(base[7:0]))};
  logic [7:0] hue_next;
  assign hue_next = hue_q + quot[7:0];
  assign rainbow_rgb = rsled_pkg::hue_to_rgb(hue_next);

  logic [31:0] h_adv;
  assign h_adv = 32'(quot * 32'(hstep_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'd1000;
      hstep_q <= 16'd250;
      blink_q <= 16'd500;
      cur_mode_q <= rsled_pkg::ModeNone;
      mode_q <= rsled_pkg::ModeNone;
      lit_q <= 1'b1;
      toggle_q <= '0;
      bstart_q <= '0;
      hstart_q <= '0;
      hue_q <= '0;
      drive_q <= '1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rsled_pkg::RegPeriod: period_q <= cfg_data_i;
          rsled_pkg::RegHue:    hstep_q <= cfg_data_i;
          rsled_pkg::RegBlink:  blink_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        mode_q <= mode_d;
        cur_mode_q <= mode_d;
        if (mode_d != cur_mode_q) begin
          if (mode_d == rsled_pkg::ModeRainbow) begin
            hstart_q <= now_ms_i;
            hue_q <= '0;
          end
          if (mode_d == rsled_pkg::ModeStart || mode_d == rsled_pkg::ModeEnd) begin
            bstart_q <= now_ms_i;
          end
        end
      end
      if (cmd_i.finish) begin
        unique case (mode_q)
          rsled_pkg::ModeUnauth, rsled_pkg::ModeStart, rsled_pkg::ModeEnd:
            drive_q <= breathe_drv;
          rsled_pkg::ModeRainbow: begin
            if (h_elapsed >= 32'(hstep_eff)) begin
              hstart_q <= hstart_q + h_adv;
              hue_q <= hue_next;
              drive_q <= ~rainbow_rgb;
            end
          end
          rsled_pkg::ModeEnroll, rsled_pkg::ModeReset: begin
            if (now_q - toggle_q >= 32'(blink_q)) begin
              toggle_q <= now_q;
              lit_q <= ~lit_q;
              drive_q <= (!lit_q) ? ~base : 24'hFFFFFF;
            end
          end
          default: drive_q <= 24'hFFFFFF;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) now_q <= now_ms_i;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.mode = mode_q;
  assign red_drive_o = drive_q[23:16];
  assign green_drive_o = drive_q[15:8];
  assign blue_drive_o = drive_q[7:0];
  assign mode_now_o = mode_q;
endmodule

FILE: hw/rtl/rsled_ctrl.sv
// Controller state machine sequencing one LED update.
module rsled_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsled_pkg::ctrl_cmd_t cmd_o,
  input  rsled_pkg::ctrl_sts_t sts_i
);
  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StDiv  = 6'b000010,
    StWait = 6'b000100,
    StIdx  = 6'b001000,
    StFin  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic is_breathe, is_rainbow;

  assign is_breathe = sts_i.mode == rsled_pkg::ModeUnauth ||
                      sts_i.mode == rsled_pkg::ModeStart || sts_i.mode == rsled_pkg::ModeEnd;
  assign is_rainbow = sts_i.mode == rsled_pkg::ModeRainbow;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.div_sel = is_rainbow;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (is_breathe || is_rainbow) begin
          cmd_o.div_start = 1'b1;
          state_d = StWait;
        end else begin
          state_d = StFin;
        end
      end
      StWait: if (sts_i.div_done) begin
        if (is_breathe) begin
          cmd_o.idx_start = 1'b1;
          state_d = StIdx;
        end else begin
          state_d = StFin;
        end
      end
      StIdx: if (sts_i.div_done) state_d = StFin;
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d = StOut;
      end
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign in_stall_o = state_q != StIdle;
  assign out_valid_o = state_q == StOut;
endmodule

FILE: hw/rtl/rgb_status_led_effect_engine.sv
// Top level of the RGB status LED effect engine.
// Channel | Direction | Handshake        | Payload
// in      | input     | valid / stall    | now_ms, authenticated, resource_select_wait, tap_wait
// out     | output    | valid / stall    | red/green/blue drive, mode_now
// cfg     | input     | valid / ready    | register index, 16-bit data
// An update uses two passes of the shared divider in breathing modes, one in rainbow mode
// and none otherwise.
// Reset loads default periods, clears effect state and turns the LED off.
// A result is held until the output side takes it; no new update enters before.
module rgb_status_led_effect_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  input  logic        authenticated_i,
  input  logic        resource_select_wait_i,
  input  logic [2:0]  tap_wait_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_drive_o,
  output logic [7:0]  green_drive_o,
  output logic [7:0]  blue_drive_o,
  output logic [2:0]  mode_now_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  rsled_pkg::ctrl_cmd_t cmd;
  rsled_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rsled_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o (cmd), .sts_i (sts)
  );

  rsled_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .sts_o (sts),
    .now_ms_i, .authenticated_i, .resource_select_wait_i, .tap_wait_i,
    .cfg_we_i (cfg_valid_i), .cfg_idx_i (cfg_index_i), .cfg_data_i,
    .red_drive_o, .green_drive_o, .blue_drive_o, .mode_now_o
  );
endmodule

FILE: hw/rtl/rsled_checker.sv
// Port-level checker for the effect engine, bound to the top level.
`include "rgb_status_led_effect_engine_assert.svh"
module rsled_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_drive_o,
  input logic [2:0] mode_now_o
);
  `RSL_ASSERT(a_busy_while_out, clk_i, rst_ni, out_valid_o |-> in_stall_o, "output pending but input open")
  `RSL_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(red_drive_o)), "stalled result changed")
  `RSL_ASSERT(a_mode_range, clk_i, rst_ni, out_valid_o |-> (mode_now_o != 3'd7), "invalid mode in result")
  `RSL_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "input open after accept")
endmodule

bind rgb_status_led_effect_engine rsled_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .red_drive_o, .mode_now_o
);

FILE: verif/rgb_status_led_effect_engine_tb.sv
// Testbench for the RGB status LED effect engine: a scoreboard checks every update against a predictor.
`timescale 1ns / 1ps

module rgb_status_led_effect_engine_tb;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] mode;
  } led_result_t;

  class led_scoreboard;
    logic [15:0] period_ms, hue_ms, blink_ms;
    logic [2:0] cur_mode;
    logic lit;
    logic [31:0] toggle_t, breathe_t, hue_t;
    logic [7:0] hue;
    logic [7:0] held [3];
    logic [7:0] sine [256];
    led_result_t pending [$];
    int mismatches;
    int checked;

    function new();
      int i;
      int k;
      logic [63:0] one, x, x2, t, s;
      logic [15:0] p;
      logic [14:0] r;
      one = 64'd1 << 30;
      for (i = 0; i < 256; i++) begin
        p = 16'((64'(i) * 64'd65536) / 64'd256);
        r = p[14:0];
        if (r > 15'd16384) r = 15'(16'd32768 - 16'(r));
        x = (64'(r) * 64'd1686629713) >> 14;
        x2 = (x * x) >> 30;
        t = one;
        t = one - ((x2 * t) >> 30) / 64'd110;
        t = one - ((x2 * t) >> 30) / 64'd72;
        t = one - ((x2 * t) >> 30) / 64'd42;
        t = one - ((x2 * t) >> 30) / 64'd20;
        t = one - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        if (s > one) s = one;
        if (p[15]) sine[i] = 8'(((one - s) * 64'd255) >> 31);
        else sine[i] = 8'(((one + s) * 64'd255) >> 31);
      end
      period_ms = 16'd1000;
      hue_ms = 16'd250;
      blink_ms = 16'd500;
      cur_mode = rsled_pkg::ModeNone;
      lit = 1'b1;
      toggle_t = '0;
      breathe_t = '0;
      hue_t = '0;
      hue = '0;
      for (k = 0; k < 3; k++) held[k] = 8'd255;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        rsled_pkg::RegPeriod: period_ms = v;
        rsled_pkg::RegHue: hue_ms = v;
        rsled_pkg::RegBlink: blink_ms = v;
        default: ;
      endcase
    endfunction

    function void set_drive(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      held[0] = 8'd255 - r;
      held[1] = 8'd255 - g;
      held[2] = 8'd255 - b;
    endfunction

    function logic [23:0] base_rgb(logic [2:0] m);
      case (m)
        rsled_pkg::ModeUnauth: return {8'd255, 8'd165, 8'd0};
        rsled_pkg::ModeEnroll: return {8'd0, 8'd0, 8'd255};
        rsled_pkg::ModeReset: return {8'd128, 8'd0, 8'd128};
        rsled_pkg::ModeStart: return {8'd0, 8'd255, 8'd0};
        rsled_pkg::ModeEnd: return {8'd255, 8'd0, 8'd0};
        default: return 24'd0;
      endcase
    endfunction

    function void breathe(logic [31:0] now, logic [2:0] m);
      logic [31:0] per, el, idx, br;
      logic [23:0] c;
      per = (period_ms == 0) ? 32'd1 : 32'(period_ms);
      el = now - breathe_t;
      idx = 32'((64'(el % per) * 64'd256) / 64'(per));
      if (idx > 255) idx = 255;
      br = 32'(sine[idx[7:0]]);
      c = base_rgb(m);
      set_drive(8'(br * c[23:16] / 255), 8'(br * c[15:8] / 255), 8'(br * c[7:0] / 255));
    endfunction

    function logic [23:0] hsv(logic [7:0] h);
      int unsigned sec, f, q, t;
      sec = h / 43;
      f = (h % 43) * 6;
      q = (255 * (255 - ((255 * f) >> 8))) >> 8;
      t = (255 * (255 - ((255 * (255 - f)) >> 8))) >> 8;
      case (sec)
        0: return {8'd255, 8'(t), 8'd0};
        1: return {8'(q), 8'd255, 8'd0};
        2: return {8'd0, 8'd255, 8'(t)};
        3: return {8'd0, 8'(q), 8'd255};
        4: return {8'(t), 8'd0, 8'd255};
        default: return {8'd255, 8'd0, 8'(q)};
      endcase
    endfunction

    function void note_update(logic [31:0] now, logic auth, logic sel, logic [2:0] tap);
      logic [2:0] m;
      logic entry;
      logic [31:0] st, el, steps;
      logic [23:0] c;
      if (!auth) m = rsled_pkg::ModeUnauth;
      else if (sel) m = rsled_pkg::ModeRainbow;
      else if (tap >= 1 && tap <= 4) m = 3'(tap + 1);
      else m = rsled_pkg::ModeIdle;
      entry = (m != cur_mode);
      cur_mode = m;
      case (m)
        rsled_pkg::ModeUnauth: breathe(now, m);
        rsled_pkg::ModeRainbow: begin
          if (entry) begin
            hue_t = now;
            hue = '0;
          end
          st = (hue_ms == 0) ? 32'd1 : 32'(hue_ms);
          el = now - hue_t;
          if (el >= st) begin
            steps = el / st;
            hue_t += steps * st;
            hue = 8'(hue + steps);
            c = hsv(hue);
            set_drive(c[23:16], c[15:8], c[7:0]);
          end
        end
        rsled_pkg::ModeEnroll, rsled_pkg::ModeReset: begin
          if (now - toggle_t >= 32'(blink_ms)) begin
            toggle_t = now;
            lit = !lit;
            c = lit ? base_rgb(m) : 24'd0;
            set_drive(c[23:16], c[15:8], c[7:0]);
          end
        end
        rsled_pkg::ModeStart, rsled_pkg::ModeEnd: begin
          if (entry) breathe_t = now;
          breathe(now, m);
        end
        default: set_drive(8'd0, 8'd0, 8'd0);
      endcase
      pending.push_back({held[0], held[1], held[2], m});
    endfunction

    function void check_result(led_result_t got);
      led_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.red !== got.red || exp_r.green !== got.green ||
          exp_r.blue !== got.blue || exp_r.mode !== got.mode) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected r%0d g%0d b%0d m%0d, got r%0d g%0d b%0d m%0d",
                   exp_r.red, exp_r.green, exp_r.blue, exp_r.mode,
                   got.red, got.green, got.blue, got.mode);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [31:0] now_ms_i = 0;
  logic authenticated_i = 0;
  logic resource_select_wait_i = 0;
  logic [2:0] tap_wait_i = 0;
  logic out_valid_o;
  logic out_stall_i = 1;
  logic [7:0] red_drive_o, green_drive_o, blue_drive_o;
  logic [2:0] mode_now_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = 0;
  logic [15:0] cfg_data_i = 0;

  rgb_status_led_effect_engine dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  led_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int cycles = 0;
  int sent = 0;
  logic [31:0] clock_ms = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[rgb_status_led_effect_engine] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({red_drive_o, green_drive_o, blue_drive_o, mode_now_o});

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic send_update(logic [31:0] now, logic auth, logic sel, logic [2:0] tap);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    now_ms_i <= now;
    authenticated_i <= auth;
    resource_select_wait_i <= sel;
    tap_wait_i <= tap;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_update(now, auth, sel, tap);
    sent++;
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_update();
    int pick;
    logic auth, sel;
    logic [2:0] tap;
    if ($urandom_range(9) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 700);
    pick = $urandom_range(99);
    auth = 1'b1;
    sel = 1'($urandom_range(1));
    tap = 3'($urandom_range(7));
    if (pick < 15) auth = 1'b0;
    else if (pick < 55) sel = (pick < 30);
    send_update(clock_ms, auth, sel, tap);
  endtask

  task automatic random_phase(int n, logic [15:0] per, logic [15:0] hs, logic [15:0] bl);
    drain();
    write_cfg(rsled_pkg::RegPeriod, per);
    write_cfg(rsled_pkg::RegHue, hs);
    write_cfg(rsled_pkg::RegBlink, bl);
    repeat (n) begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 8)) random_update();
      else random_update();
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    recv_idle_pct = 0;
    send_update(32'd0, 1, 0, 3'd0);
    send_update(32'd10, 0, 1, 3'd7);
    send_update(32'd300, 0, 0, 3'd0);
    send_update(32'd900, 1, 1, 3'd1);
    send_update(32'd1400, 1, 1, 3'd2);
    send_update(32'hffff_ffff, 1, 1, 3'd0);
    send_update(32'd600, 1, 0, 3'd1);
    send_update(32'd1200, 1, 0, 3'd1);
    send_update(32'd1300, 1, 0, 3'd2);
    send_update(32'd1800, 1, 0, 3'd2);
    send_update(32'd1900, 1, 0, 3'd3);
    send_update(32'd2150, 1, 0, 3'd3);
    send_update(32'd2200, 1, 0, 3'd4);
    send_update(32'hffff_fff0, 1, 0, 3'd4);
    send_update(32'd5, 1, 0, 3'd5);
    send_update(32'd6, 1, 0, 3'd6);
    send_update(32'd7, 1, 0, 3'd7);
    drain();
    write_cfg(rsled_pkg::RegPeriod, 16'd0);
    write_cfg(rsled_pkg::RegHue, 16'd0);
    write_cfg(rsled_pkg::RegBlink, 16'd0);
    send_update(32'd100, 0, 0, 3'd0);
    send_update(32'd101, 1, 1, 3'd0);
    send_update(32'd105, 1, 1, 3'd0);
    send_update(32'd106, 1, 0, 3'd1);
    send_update(32'd106, 1, 0, 3'd2);
    send_update(32'd107, 1, 0, 3'd4);

    send_idle_pct = 6;
    recv_idle_pct = 86;
    random_phase(400, 16'd1000, 16'd250, 16'd500);
    random_phase(200, 16'hffff, 16'hffff, 16'hffff);
    send_idle_pct = 86;
    recv_idle_pct = 6;
    random_phase(300, 16'd1, 16'd1, 16'd1);
    random_phase(250, 16'($urandom), 16'($urandom), 16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    hold_off = 400;
    random_phase(250, 16'd37, 16'd3, 16'd200);
    random_phase(350, 16'($urandom_range(1, 3000)), 16'($urandom_range(1, 300)),
                 16'($urandom_range(1, 900)));
    drain();
    $display("Sent %0d updates over all modes and several register settings; %0d results checked.",
             sent, sb.checked);
    if (sb.mismatches == 0) $display("[rgb_status_led_effect_engine] OK");
    else $display("[rgb_status_led_effect_engine] ERROR");
    $finish;
  end
endmodule
